>>> design/gbd_pkg.sv
package gbd_pkg;

    // Grid limits
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_DEPTH  = 128;

    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int Y_W    = $clog2(MAX_HEIGHT);
    localparam int Z_W    = $clog2(MAX_DEPTH);
    localparam int SLOT_W = X_W + Y_W;

    // Field widths
    localparam int DIM_W     = 8;
    localparam int SAMPLE_W  = 32;
    localparam int PAIR_W    = 2 * SAMPLE_W;
    localparam int COEF_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int MAG2_W    = PROD_W - FRAC_W;
    localparam int TERM_W    = MAG2_W + 1;
    localparam int GRAD_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    // Interior margins
    localparam int EDGE_LO = 2;
    localparam int EDGE_HI = 3;

    localparam logic [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
    localparam logic [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH    = 4'd0,
        CFG_GRID_HEIGHT   = 4'd1,
        CFG_GRID_DEPTH    = 4'd2,
        CFG_INV_DX        = 4'd3,
        CFG_INV_DY        = 4'd4,
        CFG_INV_DZ        = 4'd5,
        CFG_INV_MU        = 4'd6,
        CFG_INV_THREE_RHO = 4'd7
    } gbd_cfg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } gbd_state_t;

    // Stage enables for the arithmetic lanes
    typedef struct packed {
        logic diff_en;
        logic mul1_en;
        logic mul2_en;
    } gbd_lane_ctrl_t;

    // Current scan position and its classification
    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [Z_W-1:0] z;
        logic           interior;
        logic           last;
    } gbd_pos_t;

    // Zero acts as one, oversize acts as the maximum
    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> design/gbd_if.sv
// Sample stream: one grid point per beat
interface gbd_sample_if import gbd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pressure_sample;
    logic signed [SAMPLE_W-1:0] source_sample;

    modport source (output valid, output pressure_sample, output source_sample,
                    input ready);
    modport sink   (input valid, input pressure_sample, input source_sample,
                    output ready);
endinterface

// Result stream: one interior point per beat
interface gbd_result_if import gbd_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     last_point;

    modport source (output valid, output grad_x, output grad_y, output grad_z,
                    output last_point, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input grad_z,
                    input last_point, output ready);
endinterface

// Register write channel
interface gbd_cfg_if import gbd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/gbd_scan.sv
module gbd_scan import gbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    input  logic             advance,
    input  logic [DIM_W-1:0] w,
    input  logic [DIM_W-1:0] h,
    input  logic [DIM_W-1:0] d,
    input  logic             three_d,
    output gbd_pos_t         pos
);

    logic [X_W-1:0] x_reg, x_next;
    logic [Y_W-1:0] y_reg, y_next;
    logic [Z_W-1:0] z_reg, z_next;
    logic [X_W-1:0] x_c;
    logic [Y_W-1:0] y_c;
    logic [Z_W-1:0] z_c;
    logic           in_x, in_y, in_z;
    logic           end_x, end_y, end_z;

    // Clamp the position into the current grid
    always_comb
    begin
        x_c = (DIM_W'(x_reg) >= w) ? X_W'(w - DIM_W'(1)) : x_reg;
        y_c = (DIM_W'(y_reg) >= h) ? Y_W'(h - DIM_W'(1)) : y_reg;
        z_c = (DIM_W'(z_reg) >= d) ? Z_W'(d - DIM_W'(1)) : z_reg;
    end

    // Interior test and last interior point
    always_comb
    begin
        in_x  = (DIM_W'(x_c) >= DIM_W'(EDGE_LO)) && (DIM_W'(x_c) + DIM_W'(EDGE_HI) < w);
        in_y  = (DIM_W'(y_c) >= DIM_W'(EDGE_LO)) && (DIM_W'(y_c) + DIM_W'(EDGE_HI) < h);
        in_z  = (DIM_W'(z_c) >= DIM_W'(EDGE_LO)) && (DIM_W'(z_c) + DIM_W'(EDGE_HI) < d);
        end_x = (DIM_W'(x_c) + DIM_W'(EDGE_HI + 1) == w);
        end_y = (DIM_W'(y_c) + DIM_W'(EDGE_HI + 1) == h);
        end_z = (DIM_W'(z_c) + DIM_W'(EDGE_HI + 1) == d);
        pos.x        = x_c;
        pos.y        = y_c;
        pos.z        = z_c;
        pos.interior = in_x && in_y && (!three_d || in_z);
        pos.last     = end_x && end_y && (!three_d || end_z);
    end

    // Raster step, x fastest
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (restart)
        begin
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end
        else if (advance)
        begin
            x_next = x_c;
            y_next = y_c;
            z_next = z_c;
            if (DIM_W'(x_c) + DIM_W'(1) < w)
                x_next = x_c + X_W'(1);
            else
            begin
                x_next = '0;
                if (DIM_W'(y_c) + DIM_W'(1) < h)
                    y_next = y_c + Y_W'(1);
                else
                begin
                    y_next = '0;
                    z_next = (DIM_W'(z_c) + DIM_W'(1) < d) ? z_c + Z_W'(1) : '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

>>> design/gbd_store.sv
module gbd_store import gbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [X_W-1:0]    x,
    input  logic [Y_W-1:0]    y,
    input  logic              wr_en,
    input  logic [PAIR_W-1:0] cur,
    output logic [PAIR_W-1:0] left,
    output logic [PAIR_W-1:0] up,
    output logic [PAIR_W-1:0] back
);

    // Pressure in the low half, source in the high half
    logic [PAIR_W-1:0] row_mem   [MAX_WIDTH];
    logic [PAIR_W-1:0] plane_mem [MAX_WIDTH * MAX_HEIGHT];

    logic [PAIR_W-1:0] left_reg;
    logic [PAIR_W-1:0] up_reg;
    logic [PAIR_W-1:0] back_reg;
    logic [X_W-1:0]    wr_x_reg;
    logic [SLOT_W-1:0] wr_slot_reg;
    logic [SLOT_W-1:0] slot;

    assign slot = {y, x};

    // Neighbor reads, address kept for the write-back
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            up_reg      <= row_mem[x];
            back_reg    <= plane_mem[slot];
            wr_x_reg    <= x;
            wr_slot_reg <= slot;
        end
    end

    // Write-back of the current point
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_x_reg]      <= cur;
            plane_mem[wr_slot_reg] <= cur;
        end
    end

    // Left neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (wr_en)
            left_reg <= cur;
    end

    assign left = left_reg;
    assign up   = up_reg;
    assign back = back_reg;

endmodule

>>> design/gbd_term.sv
module gbd_term import gbd_pkg::*;
(
    input  logic                       clk,
    input  gbd_lane_ctrl_t             ctrl,
    input  logic signed [SAMPLE_W-1:0] cur,
    input  logic signed [SAMPLE_W-1:0] prev,
    input  logic [COEF_W-1:0]          inv_d,
    input  logic [COEF_W-1:0]          inv_c,
    output logic signed [TERM_W-1:0]   term
);

    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]        mag_full;
    logic                     neg_reg;
    logic [SAMPLE_W-1:0]      mag_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [COEF_W-1:0]        m1;
    logic [SAMPLE_W-1:0]      mul_a;
    logic [COEF_W-1:0]        mul_b;
    logic [PROD_W-1:0]        prod;
    logic [MAG2_W-1:0]        m2;

    // Exact difference; its magnitude always fits 32 bits
    always_comb
    begin
        diff     = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
        mag_full = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    end

    // First pass scales by the spacing, second by the material constant
    always_comb
    begin
        m1    = (prod_reg[PROD_W-1:COEF_W+FRAC_W] != '0) ? '1
                                                         : prod_reg[COEF_W+FRAC_W-1:FRAC_W];
        mul_a = ctrl.mul1_en ? mag_reg : m1;
        mul_b = ctrl.mul1_en ? inv_d : inv_c;
        prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.diff_en)
        begin
            neg_reg <= diff[SAMPLE_W];
            mag_reg <= mag_full[SAMPLE_W-1:0];
        end
        if (ctrl.mul1_en || ctrl.mul2_en)
            prod_reg <= prod;
    end

    // Signed term from the truncated magnitude
    always_comb
    begin
        m2   = prod_reg[PROD_W-1:FRAC_W];
        term = neg_reg ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
    end

endmodule

>>> design/gbd_axis.sv
module gbd_axis import gbd_pkg::*;
(
    input  logic                       clk,
    input  gbd_lane_ctrl_t             ctrl,
    input  logic [PAIR_W-1:0]          cur,
    input  logic [PAIR_W-1:0]          prev,
    input  logic [COEF_W-1:0]          inv_d,
    input  logic [COEF_W-1:0]          inv_mu,
    input  logic [COEF_W-1:0]          inv_three_rho,
    output logic signed [GRAD_W-1:0]   grad
);

    logic signed [TERM_W-1:0] term_p;
    logic signed [TERM_W-1:0] term_s;
    logic signed [TERM_W:0]   g;
    logic                     sat_hi;
    logic                     sat_lo;

    // Pressure term
    gbd_term u_term_p (
        .clk   (clk),
        .ctrl  (ctrl),
        .cur   (cur[SAMPLE_W-1:0]),
        .prev  (prev[SAMPLE_W-1:0]),
        .inv_d (inv_d),
        .inv_c (inv_mu),
        .term  (term_p)
    );

    // Source term
    gbd_term u_term_s (
        .clk   (clk),
        .ctrl  (ctrl),
        .cur   (cur[PAIR_W-1:SAMPLE_W]),
        .prev  (prev[PAIR_W-1:SAMPLE_W]),
        .inv_d (inv_d),
        .inv_c (inv_three_rho),
        .term  (term_s)
    );

    // Exact subtract, then saturate to Q16.16
    always_comb
    begin
        g      = {term_p[TERM_W-1], term_p} - {term_s[TERM_W-1], term_s};
        sat_hi = !g[TERM_W] && (g[TERM_W-1:GRAD_W-1] != '0);
        sat_lo =  g[TERM_W] && (g[TERM_W-1:GRAD_W-1] != '1);
        if (sat_hi)
            grad = GRAD_MAX;
        else if (sat_lo)
            grad = GRAD_MIN;
        else
            grad = g[GRAD_W-1:0];
    end

endmodule

>>> design/grid_backward_difference_gradient.sv
// Backward-difference gradient over a 2D or 3D grid streamed in raster order
// (x fastest), one pressure/source pair per sample beat. For every interior point
// (index 2 up to size-4 on each active axis) one result beat carries the x, y and z
// gradients, saturated signed Q16.16, with last_point set on the final interior
// point; grad_z is 0 when grid_depth is 0 or 1. Points on the margin give no result.
// The previous row and previous plane sit in two single-port synchronous RAMs:
// a margin point passes through accept (with the RAM read) and write-back; an
// interior point adds two passes through each term lane's multiplier and the
// output load, which waits only while the result register is still held by the sink.
// The RAMs need no clearing pass: unwritten entries feed only dropped results.
// Writing a dimension register restarts the scan at point (0,0,0); configure only
// while idle.
module grid_backward_difference_gradient import gbd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    gbd_cfg_if.sink      cfg,
    gbd_sample_if.sink   sample,
    gbd_result_if.source result
);

    // Configuration registers
    logic [DIM_W-1:0]  grid_width_reg;
    logic [DIM_W-1:0]  grid_height_reg;
    logic [DIM_W-1:0]  grid_depth_reg;
    logic [COEF_W-1:0] inv_dx_reg;
    logic [COEF_W-1:0] inv_dy_reg;
    logic [COEF_W-1:0] inv_dz_reg;
    logic [COEF_W-1:0] inv_mu_reg;
    logic [COEF_W-1:0] inv_three_rho_reg;
    logic              cfg_wr;
    logic              dim_wr;

    logic [DIM_W-1:0]  w, h, d;
    logic              three_d;

    gbd_state_t        state_reg, state_next;
    gbd_lane_ctrl_t    lane_ctrl;
    gbd_pos_t          pos;
    logic              accept;
    logic              store_wr;
    logic              out_load;

    logic [PAIR_W-1:0] cur_reg;
    logic              inside_reg;
    logic              last_reg;
    logic [PAIR_W-1:0] left, up, back;
    logic signed [GRAD_W-1:0] gx, gy, gz;

    logic                     out_valid_reg, out_valid_next;
    logic signed [GRAD_W-1:0] grad_x_reg, grad_y_reg, grad_z_reg;
    logic                     last_point_reg;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign dim_wr    = cfg_wr && ((cfg.index == CFG_GRID_WIDTH) ||
                                  (cfg.index == CFG_GRID_HEIGHT) ||
                                  (cfg.index == CFG_GRID_DEPTH));

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= DIM_W'(128);
            grid_height_reg   <= DIM_W'(128);
            grid_depth_reg    <= DIM_W'(1);
            inv_dx_reg        <= COEF_W'(65536);
            inv_dy_reg        <= COEF_W'(65536);
            inv_dz_reg        <= COEF_W'(65536);
            inv_mu_reg        <= COEF_W'(65536);
            inv_three_rho_reg <= COEF_W'(21845);
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                CFG_GRID_WIDTH:    grid_width_reg    <= cfg.data[DIM_W-1:0];
                CFG_GRID_HEIGHT:   grid_height_reg   <= cfg.data[DIM_W-1:0];
                CFG_GRID_DEPTH:    grid_depth_reg    <= cfg.data[DIM_W-1:0];
                CFG_INV_DX:        inv_dx_reg        <= cfg.data[COEF_W-1:0];
                CFG_INV_DY:        inv_dy_reg        <= cfg.data[COEF_W-1:0];
                CFG_INV_DZ:        inv_dz_reg        <= cfg.data[COEF_W-1:0];
                CFG_INV_MU:        inv_mu_reg        <= cfg.data[COEF_W-1:0];
                CFG_INV_THREE_RHO: inv_three_rho_reg <= cfg.data[COEF_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective grid size
    always_comb
    begin
        w       = dim_clamp(grid_width_reg, DIM_W'(MAX_WIDTH));
        h       = dim_clamp(grid_height_reg, DIM_W'(MAX_HEIGHT));
        three_d = grid_depth_reg > DIM_W'(1);
        d       = three_d ? dim_clamp(grid_depth_reg, DIM_W'(MAX_DEPTH)) : DIM_W'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        sample.ready      = 1'b0;
        lane_ctrl.diff_en = 1'b0;
        lane_ctrl.mul1_en = 1'b0;
        lane_ctrl.mul2_en = 1'b0;
        store_wr          = 1'b0;
        out_load          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                lane_ctrl.diff_en = 1'b1;
                store_wr          = 1'b1;
                state_next        = inside_reg ? ST_MUL1 : ST_IDLE;
            end
            ST_MUL1:
            begin
                lane_ctrl.mul1_en = 1'b1;
                state_next        = ST_MUL2;
            end
            ST_MUL2:
            begin
                lane_ctrl.mul2_en = 1'b1;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign accept = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture of the accepted point
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg    <= {sample.source_sample, sample.pressure_sample};
            inside_reg <= pos.interior;
            last_reg   <= pos.last;
        end
    end

    gbd_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (dim_wr),
        .advance (accept),
        .w       (w),
        .h       (h),
        .d       (d),
        .three_d (three_d),
        .pos     (pos)
    );

    gbd_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .x     (pos.x),
        .y     (pos.y),
        .wr_en (store_wr),
        .cur   (cur_reg),
        .left  (left),
        .up    (up),
        .back  (back)
    );

    gbd_axis u_axis_x (
        .clk           (clk),
        .ctrl          (lane_ctrl),
        .cur           (cur_reg),
        .prev          (left),
        .inv_d         (inv_dx_reg),
        .inv_mu        (inv_mu_reg),
        .inv_three_rho (inv_three_rho_reg),
        .grad          (gx)
    );

    gbd_axis u_axis_y (
        .clk           (clk),
        .ctrl          (lane_ctrl),
        .cur           (cur_reg),
        .prev          (up),
        .inv_d         (inv_dy_reg),
        .inv_mu        (inv_mu_reg),
        .inv_three_rho (inv_three_rho_reg),
        .grad          (gy)
    );

    gbd_axis u_axis_z (
        .clk           (clk),
        .ctrl          (lane_ctrl),
        .cur           (cur_reg),
        .prev          (back),
        .inv_d         (inv_dz_reg),
        .inv_mu        (inv_mu_reg),
        .inv_three_rho (inv_three_rho_reg),
        .grad          (gz)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            grad_x_reg     <= gx;
            grad_y_reg     <= gy;
            grad_z_reg     <= three_d ? gz : '0;
            last_point_reg <= last_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.grad_x     = grad_x_reg;
    assign result.grad_y     = grad_y_reg;
    assign result.grad_z     = grad_z_reg;
    assign result.last_point = last_point_reg;

endmodule
